// ===== hw/rtl/gif_lzw_decoder_unit_assert.svh =====
// Assertion macros for the GIF LZW decoder.
// Used by the decoder top level; compiles to nothing under SYNTHESIS.
`ifndef GIF_LZW_DECODER_UNIT_ASSERT_SVH
`define GIF_LZW_DECODER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define GLD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define GLD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define GLD_ASSERT(name, prop, msg)
`define GLD_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/gld_pkg.sv =====
// Shared types and constants for the GIF LZW decoder.
// No dependencies.
package gld_pkg;

  localparam int CODE_BITS_DEF = 12;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_BYTE  = 2'd1,
    KIND_PULL  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    STS_PIXEL   = 3'd0,
    STS_ACCEPT  = 3'd1,
    STS_NEED    = 3'd2,
    STS_REFUSE  = 3'd3,
    STS_END     = 3'd4,
    STS_EXHAUST = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_POP,
    ST_FIRST_R,
    ST_WALK,
    ST_WALK_R,
    ST_FINAL_R,
    ST_EMIT
  } state_t;

endpackage

// ===== hw/rtl/gld_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module gld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/gld_dict.sv =====
// LZW dictionary: prefix and suffix memories with fill-count masking.
// Depends on gld_ram. Entries outside the filled range read as cleared.
module gld_dict #(
  parameter int CODE_BITS = gld_pkg::CODE_BITS_DEF
) (
  input  logic                 clk,
  input  logic [CODE_BITS-1:0] rd_addr,
  input  logic                 wr_en,
  input  logic [CODE_BITS-1:0] wr_addr,
  input  logic [CODE_BITS-1:0] wr_prefix,
  input  logic [7:0]           wr_suffix,
  input  logic [CODE_BITS:0]   root_end,
  input  logic [CODE_BITS:0]   next_free,
  output logic [CODE_BITS-1:0] prefix_val,
  output logic [7:0]           suffix_val
);

  localparam int DEPTH = 1 << CODE_BITS;
  localparam int CW = CODE_BITS + 1;

  logic [CODE_BITS-1:0] rd_idx;
  logic [CODE_BITS-1:0] pfx_raw;
  logic [7:0]           sfx_raw;
  logic [CODE_BITS:0]   idx_ext;

  gld_ram #(.WIDTH(CODE_BITS), .DEPTH(DEPTH)) u_prefix (
    .clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(wr_prefix),
    .raddr(rd_addr), .rdata(pfx_raw)
  );

  gld_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_suffix (
    .clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(wr_suffix),
    .raddr(rd_addr), .rdata(sfx_raw)
  );

  always_ff @(posedge clk) begin
    rd_idx <= rd_addr;
  end

  // Roots are identity, entries written since the last clear are live, rest zero.
  always_comb begin
    idx_ext = {1'b0, rd_idx};
    if (idx_ext < root_end) begin
      prefix_val = '0;
      suffix_val = rd_idx[7:0];
    end else if (idx_ext >= root_end + CW'(2) && idx_ext < next_free) begin
      prefix_val = pfx_raw;
      suffix_val = sfx_raw;
    end else begin
      prefix_val = '0;
      suffix_val = '0;
    end
  end

endmodule

// ===== hw/rtl/gif_lzw_decoder_unit.sv =====
// GIF LZW decoder top level: handshake, bit reader, decode sequencer, stack.
// Depends on gld_pkg, gld_dict, gld_ram and gif_lzw_decoder_unit_assert.svh.
// Start, data and unused items go from idle straight to emit; a pull goes
// through the check state, which pops the stack, reads a first code, reports
// a short pull or an end code, skips clears, or walks a code onto the stack.
// Reset is synchronous and equals a start with minimum code size 8; no sweep.
`include "gif_lzw_decoder_unit_assert.svh"
module gif_lzw_decoder_unit #(
  parameter int CODE_BITS = gld_pkg::CODE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       min_code_size_we,
  input  logic [3:0] min_code_size,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] kind,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] status,
  output logic [7:0] pixel_index
);

  localparam int AW = CODE_BITS;
  localparam int CW = CODE_BITS + 1;
  localparam logic [CW-1:0] TABLE_SIZE = CW'(1) << CODE_BITS;

  gld_pkg::state_t state, state_next;

  logic [3:0]    cfg_size;
  logic [3:0]    active, active_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [3:0]    cw, cw_next;
  logic [CW-1:0] nf, nf_next;
  logic [CW-1:0] wl, wl_next;
  logic [7:0]    fs, fs_next;
  logic [AW-1:0] prev, prev_next;
  logic          aw, aw_next;
  logic [23:0]   holder, holder_next;
  logic [4:0]    bc, bc_next;
  logic [7:0]    br, br_next;
  logic          done, done_next;
  logic [AW-1:0] cur, cur_next;
  logic [AW-1:0] incode, incode_next;
  logic [2:0]    res_sts, res_sts_next;
  logic [7:0]    res_pix, res_pix_next;

  logic [CW-1:0] cc;
  logic [AW-1:0] code_now;
  logic [AW-1:0] mask;
  logic [3:0]    clamp;

  logic          tbl_we;
  logic [AW-1:0] tbl_raddr;
  logic [AW-1:0] pfx_val;
  logic [7:0]    sfx_val;

  logic          stk_we;
  logic [AW-1:0] stk_waddr;
  logic [7:0]    stk_wdata;
  logic [AW-1:0] stk_raddr;
  logic [7:0]    stk_rdata;
  logic [CW-1:0] cnt_m1;
  logic          out_load;

  assign cc       = CW'(1) << active;
  assign mask     = ~({AW{1'b1}} << cw);
  assign code_now = holder[AW-1:0] & mask;
  assign cnt_m1   = cnt - CW'(1);
  assign in_stall = (state != gld_pkg::ST_IDLE);
  assign clamp    = (cfg_size < 4'd2) ? 4'd2 : (cfg_size > 4'd8) ? 4'd8 : cfg_size;
  assign out_load = (state == gld_pkg::ST_EMIT) && (!out_valid || !out_stall);

  gld_dict #(.CODE_BITS(CODE_BITS)) u_dict (
    .clk(clk), .rd_addr(tbl_raddr), .wr_en(tbl_we), .wr_addr(nf[AW-1:0]),
    .wr_prefix(prev), .wr_suffix(fs_next), .root_end(cc), .next_free(nf),
    .prefix_val(pfx_val), .suffix_val(sfx_val)
  );

  gld_ram #(.WIDTH(8), .DEPTH(1 << CODE_BITS)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_size <= 4'd8;
    end else if (min_code_size_we) begin
      cfg_size <= min_code_size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= gld_pkg::ST_IDLE;
      active    <= 4'd8;
      cnt       <= '0;
      cw        <= 4'd9;
      nf        <= CW'(258);
      wl        <= CW'(512);
      fs        <= '0;
      prev      <= '0;
      aw        <= 1'b1;
      holder    <= '0;
      bc        <= '0;
      br        <= '0;
      done      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      active <= active_next;
      cnt    <= cnt_next;
      cw     <= cw_next;
      nf     <= nf_next;
      wl     <= wl_next;
      fs     <= fs_next;
      prev   <= prev_next;
      aw     <= aw_next;
      holder <= holder_next;
      bc     <= bc_next;
      br     <= br_next;
      done   <= done_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur     <= cur_next;
    incode  <= incode_next;
    res_sts <= res_sts_next;
    res_pix <= res_pix_next;
    if (out_load) begin
      status      <= res_sts;
      pixel_index <= (res_sts == gld_pkg::STS_PIXEL) ? res_pix : 8'd0;
    end
  end

  always_comb begin
    state_next   = state;
    active_next  = active;
    cnt_next     = cnt;
    cw_next      = cw;
    nf_next      = nf;
    wl_next      = wl;
    fs_next      = fs;
    prev_next    = prev;
    aw_next      = aw;
    holder_next  = holder;
    bc_next      = bc;
    br_next      = br;
    done_next    = done;
    cur_next     = cur;
    incode_next  = incode;
    res_sts_next = res_sts;
    res_pix_next = res_pix;
    tbl_we       = 1'b0;
    tbl_raddr    = cur;
    stk_we       = 1'b0;
    stk_waddr    = cnt[AW-1:0];
    stk_wdata    = fs;
    stk_raddr    = cnt_m1[AW-1:0];

    unique case (state)
      gld_pkg::ST_IDLE: begin
        if (in_valid) begin
          res_sts_next = gld_pkg::STS_ACCEPT;
          res_pix_next = '0;
          state_next   = gld_pkg::ST_EMIT;
          case (kind)
            gld_pkg::KIND_START: begin
              active_next = clamp;
              cw_next     = clamp + 4'd1;
              nf_next     = (CW'(1) << clamp) + CW'(2);
              wl_next     = CW'(2) << clamp;
              cnt_next    = '0;
              fs_next     = '0;
              prev_next   = '0;
              aw_next     = 1'b1;
              holder_next = '0;
              bc_next     = '0;
              br_next     = '0;
              done_next   = 1'b0;
            end
            gld_pkg::KIND_BYTE: begin
              if (done) begin
                res_sts_next = gld_pkg::STS_REFUSE;
              end else if (br == 8'd0) begin
                if (data_byte == 8'd0) begin
                  done_next = 1'b1;
                end else begin
                  br_next = data_byte;
                end
              end else if (bc > 5'd16) begin
                res_sts_next = gld_pkg::STS_REFUSE;
              end else begin
                holder_next = holder | (24'(data_byte) << bc);
                bc_next     = bc + 5'd8;
                br_next     = br - 8'd1;
              end
            end
            gld_pkg::KIND_PULL: begin
              state_next = gld_pkg::ST_CHECK;
            end
            default: begin
            end
          endcase
        end
      end
      gld_pkg::ST_CHECK: begin
        tbl_raddr = code_now;
        if (cnt != '0) begin
          cnt_next   = cnt_m1;
          state_next = gld_pkg::ST_POP;
        end else if (bc < 5'(cw)) begin
          res_sts_next = done ? gld_pkg::STS_EXHAUST : gld_pkg::STS_NEED;
          res_pix_next = '0;
          state_next   = gld_pkg::ST_EMIT;
        end else if (CW'(code_now) == cc + CW'(1)) begin
          res_sts_next = gld_pkg::STS_END;
          res_pix_next = '0;
          state_next   = gld_pkg::ST_EMIT;
        end else begin
          holder_next = holder >> cw;
          bc_next     = bc - 5'(cw);
          if (CW'(code_now) == cc) begin
            // clear: reset fill count, stay here for the next code
            cw_next  = active + 4'd1;
            nf_next  = cc + CW'(2);
            wl_next  = cc << 1;
            cnt_next = '0;
            aw_next  = 1'b1;
          end else if (aw) begin
            cur_next   = code_now;
            state_next = gld_pkg::ST_FIRST_R;
          end else begin
            incode_next = code_now;
            state_next  = gld_pkg::ST_WALK;
            if (CW'(code_now) >= nf) begin
              stk_we    = 1'b1;
              stk_waddr = '0;
              stk_wdata = fs;
              cnt_next  = CW'(1);
              cur_next  = prev;
            end else begin
              cur_next = code_now;
            end
          end
        end
      end
      gld_pkg::ST_POP: begin
        res_sts_next = gld_pkg::STS_PIXEL;
        res_pix_next = stk_rdata;
        state_next   = gld_pkg::ST_EMIT;
      end
      gld_pkg::ST_FIRST_R: begin
        fs_next      = sfx_val;
        prev_next    = cur;
        aw_next      = 1'b0;
        res_sts_next = gld_pkg::STS_PIXEL;
        res_pix_next = sfx_val;
        state_next   = gld_pkg::ST_EMIT;
      end
      gld_pkg::ST_WALK: begin
        tbl_raddr = cur;
        if (CW'(cur) >= cc && cnt < TABLE_SIZE - CW'(1)) begin
          state_next = gld_pkg::ST_WALK_R;
        end else begin
          state_next = gld_pkg::ST_FINAL_R;
        end
      end
      gld_pkg::ST_WALK_R: begin
        // push this link and issue the read for the next one
        stk_we    = 1'b1;
        stk_wdata = sfx_val;
        cnt_next  = cnt + CW'(1);
        cur_next  = pfx_val;
        tbl_raddr = pfx_val;
        if (CW'(pfx_val) >= cc && cnt + CW'(1) < TABLE_SIZE - CW'(1)) begin
          state_next = gld_pkg::ST_WALK_R;
        end else begin
          state_next = gld_pkg::ST_FINAL_R;
        end
      end
      gld_pkg::ST_FINAL_R: begin
        fs_next   = sfx_val;
        stk_we    = 1'b1;
        stk_wdata = sfx_val;
        cnt_next  = cnt + CW'(1);
        if (nf < TABLE_SIZE) begin
          tbl_we  = 1'b1;
          nf_next = nf + CW'(1);
          if (nf + CW'(1) >= wl && wl < TABLE_SIZE) begin
            wl_next = wl << 1;
            cw_next = cw + 4'd1;
          end
        end
        prev_next  = incode;
        state_next = gld_pkg::ST_CHECK;
      end
      gld_pkg::ST_EMIT: begin
        if (!out_valid || !out_stall) begin
          state_next = gld_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = gld_pkg::ST_IDLE;
      end
    endcase
  end

  `GLD_ASSERT(a_stack_bound, cnt <= TABLE_SIZE, "stack count beyond table size")
  `GLD_ASSERT(a_push_room, (state != gld_pkg::ST_WALK_R) || (cnt < TABLE_SIZE - CW'(1)), "chain push without room")
  `GLD_ASSERT(a_table_bound, (nf <= TABLE_SIZE) && (cw <= 4'(CODE_BITS)), "table fill or code width overrun")
  `GLD_ASSERT_NEXT(a_item_busy, in_valid && !in_stall, state != gld_pkg::ST_IDLE, "accepted item left no work")

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for gif_lzw_decoder_unit: builds LZW code streams,
// drives them with pulls under random idling, and checks each result in order.
// Depends on gld_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb;
  import gld_pkg::*;

  typedef struct packed {
    status_t    st;
    logic [7:0] px;
  } pix_result_t;

  // Decoder state mirror plus the queue of predicted results.
  class lzw_scoreboard;
    bit [11:0]   prefix_tbl[4096];
    bit [7:0]    suffix_tbl[4096];
    bit [7:0]    chain_stk[4096];
    int unsigned stk_n, width, free_code, limit, first_sym, prev_code, fresh;
    int unsigned holder, nbits, blk_left, done, reg_size, size;
    pix_result_t pending_q[$];
    int          errors, checked;

    function new();
      reg_size = 8;
      restart();
    endfunction

    function int unsigned clr();
      return 1 << size;
    endfunction

    function void clear_dict();
      for (int i = 0; i < 4096; i++) begin
        prefix_tbl[i] = 0;
        suffix_tbl[i] = (i < clr()) ? i[7:0] : 8'd0;
      end
      width = size + 1;
      free_code = clr() + 2;
      limit = 2 * clr();
      stk_n = 0;
    endfunction

    function void restart();
      size = (reg_size < 2) ? 2 : (reg_size > 8) ? 8 : reg_size;
      clear_dict();
      first_sym = 0;
      prev_code = 0;
      fresh = 1;
      holder = 0;
      nbits = 0;
      blk_left = 0;
      done = 0;
    endfunction

    function status_t take(int unsigned b);
      if (done) return STS_REFUSE;
      if (blk_left == 0) begin
        if (b == 0) done = 1;
        else blk_left = b;
        return STS_ACCEPT;
      end
      if (nbits + 8 > 24) return STS_REFUSE;
      holder = (holder | (b << nbits)) & 24'hFFFFFF;
      nbits += 8;
      blk_left--;
      return STS_ACCEPT;
    endfunction

    function status_t pull(output logic [7:0] px);
      int unsigned code, incode;
      px = 0;
      forever begin
        if (stk_n > 0) begin
          stk_n--;
          px = chain_stk[stk_n & 4095];
          return STS_PIXEL;
        end
        if (nbits < width) return done ? STS_EXHAUST : STS_NEED;
        code = holder & ((1 << width) - 1);
        if (code == clr() + 1) return STS_END;
        holder >>= width;
        nbits -= width;
        if (code == clr()) begin
          clear_dict();
          fresh = 1;
          continue;
        end
        code &= 4095;
        if (fresh) begin
          fresh = 0;
          first_sym = suffix_tbl[code];
          prev_code = code;
          px = first_sym;
          return STS_PIXEL;
        end
        incode = code;
        if (code >= free_code) begin
          chain_stk[0] = first_sym;
          stk_n = 1;
          code = prev_code & 4095;
        end
        while (code >= clr() && stk_n < 4095) begin
          chain_stk[stk_n] = suffix_tbl[code];
          stk_n++;
          code = prefix_tbl[code];
        end
        first_sym = suffix_tbl[code];
        chain_stk[stk_n & 4095] = first_sym;
        stk_n++;
        if (free_code < 4096) begin
          prefix_tbl[free_code] = prev_code;
          suffix_tbl[free_code] = first_sym;
          free_code++;
          if (free_code >= limit && limit < 4096) begin
            limit *= 2;
            width++;
          end
        end
        prev_code = incode;
      end
    endfunction

    function status_t note_item(logic [1:0] k, logic [7:0] b);
      pix_result_t r;
      r.st = STS_ACCEPT;
      r.px = 0;
      case (k)
        KIND_START: restart();
        KIND_BYTE:  r.st = take(b);
        KIND_PULL:  r.st = pull(r.px);
        default:    ;
      endcase
      pending_q.push_back(r);
      return r.st;
    endfunction

    function void check_result(logic [2:0] st, logic [7:0] px);
      pix_result_t e;
      checked++;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result with nothing pending: status %0d pixel %0d", st, px);
        return;
      end
      e = pending_q.pop_front();
      if (st !== e.st || px !== e.px) begin
        errors++;
        if (errors <= 10)
          $display("mismatch at result %0d: expected status %0d pixel %0d, got %0d %0d",
                   checked, e.st, e.px, st, px);
      end
    endfunction
  endclass

  logic       clk, rst;
  logic       min_code_size_we;
  logic [3:0] min_code_size;
  logic       in_valid, in_stall;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic       out_valid, out_stall;
  logic [2:0] status;
  logic [7:0] pixel_index;

  gif_lzw_decoder_unit u_top (
    .clk(clk), .rst(rst),
    .min_code_size_we(min_code_size_we), .min_code_size(min_code_size),
    .in_valid(in_valid), .in_stall(in_stall), .kind(kind), .data_byte(data_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .pixel_index(pixel_index)
  );

  lzw_scoreboard sb = new();
  int sent_items, images, idle_cycles, burst_left;
  int stall_left, stall_mode;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Receiver: checks each result it takes; the stall pattern switches among four styles.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(status, pixel_index);
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_left % 8) < 3;
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 60000) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send(input logic [1:0] k, input logic [7:0] b, output status_t st);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    kind <= k;
    data_byte <= b;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    st = sb.note_item(k, b);
    sent_items++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_q.size() > 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_size(input int v);
    drain();
    min_code_size_we <= 1'b1;
    min_code_size <= v[3:0];
    @(posedge clk);
    min_code_size_we <= 1'b0;
    sb.reg_size = v;
  endtask

  // Build one image as a code stream, pack it into sub-blocks and feed it with
  // interleaved pulls. junk allows codes outside the table; lit_only makes the
  // non-junk data codes literals so the dictionary can fill up cheaply.
  task automatic run_image(input int msize, input int ncodes, input bit junk,
                           input bit lit_only, input bit with_end);
    int unsigned a, cc, w, nf, lim, code, acc, nacc, idx, chunk, pos, refusals;
    bit first;
    byte unsigned data_q[$], stream_q[$];
    status_t st;
    write_size(msize);
    send(KIND_START, $urandom, st);
    a = (msize < 2) ? 2 : (msize > 8) ? 8 : msize;
    cc = 1 << a;
    w = a + 1; nf = cc + 2; lim = 2 * cc; first = 1;
    acc = 0; nacc = 0;
    for (int i = -int'($urandom_range(0, 2)); i < ncodes + 1; i++) begin
      if (i < 0 || (!lit_only && !first && i < ncodes && $urandom_range(0, 15) == 0)) begin
        code = cc;
      end else if (i == ncodes) begin
        if (!with_end) break;
        code = cc + 1;
      end else if (junk && $urandom_range(0, 7) == 0) begin
        code = $urandom_range(cc + 2, (1 << w) - 1);
      end else if (first || lit_only) begin
        code = $urandom_range(0, cc - 1);
      end else begin
        code = $urandom_range(0, nf);
        if (code == cc || code == cc + 1) code = $urandom_range(0, cc - 1);
      end
      acc |= code << nacc;
      nacc += w;
      while (nacc >= 8) begin
        data_q.push_back(acc[7:0]);
        acc >>= 8;
        nacc -= 8;
      end
      if (code == cc) begin
        w = a + 1; nf = cc + 2; lim = 2 * cc; first = 1;
      end else if (first) begin
        first = 0;
      end else if (nf < 4096) begin
        nf++;
        if (nf >= lim && lim < 4096) begin
          lim *= 2;
          w++;
        end
      end
    end
    if (nacc > 0) data_q.push_back(acc[7:0]);
    pos = 0;
    while (pos < data_q.size()) begin
      chunk = ($urandom_range(0, 9) == 0) ? 255 : $urandom_range(1, 12);
      if (chunk > data_q.size() - pos) chunk = data_q.size() - pos;
      stream_q.push_back(chunk);
      repeat (chunk) begin
        stream_q.push_back(data_q[pos]);
        pos++;
      end
    end
    stream_q.push_back(0);
    if ($urandom_range(0, 3) == 0) stream_q.push_back($urandom);
    idx = 0;
    refusals = 0;
    while (idx < stream_q.size()) begin
      if ($urandom_range(0, 1) == 0) begin
        send(KIND_PULL, $urandom, st);
      end else begin
        send(KIND_BYTE, stream_q[idx], st);
        // a refused byte is retried unless the stream is over or stuck
        if (st != STS_REFUSE || sb.done || ++refusals > 4) begin
          idx++;
          refusals = 0;
        end
      end
    end
    do send(KIND_PULL, $urandom, st); while (st == STS_PIXEL);
    send(KIND_PULL, $urandom, st);
    images++;
  endtask

  initial begin
    status_t st;
    rst = 1'b1;
    in_valid = 1'b0;
    kind = '0;
    data_byte = '0;
    min_code_size_we = 1'b0;
    min_code_size = '0;
    out_stall = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Straight out of reset: short pull, unused kind, full holder, end of data.
    send(KIND_PULL, 8'h00, st);
    send(2'd3, 8'hFF, st);
    send(KIND_BYTE, 8'd4, st);
    send(KIND_BYTE, 8'hFF, st);
    send(KIND_BYTE, 8'h00, st);
    send(KIND_BYTE, 8'hAA, st);
    send(KIND_BYTE, 8'h55, st);
    repeat (4) send(KIND_PULL, 8'hFF, st);
    send(KIND_BYTE, 8'h55, st);
    send(KIND_BYTE, 8'h00, st);
    send(KIND_BYTE, 8'h7E, st);
    send(KIND_PULL, 8'h00, st);
    send(KIND_PULL, 8'h00, st);
    run_image(2, 6, 0, 0, 1);
    run_image(0, 4, 1, 0, 1);
    run_image(15, 4, 0, 0, 0);

    while (sent_items < 1650) begin
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(5, 20)) send($urandom, $urandom, st);
      end else begin
        run_image(($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : $urandom_range(2, 8),
                  $urandom_range(3, 60), $urandom_range(0, 4) == 0,
                  $urandom_range(0, 5) == 0, $urandom_range(0, 7) != 0);
      end
    end
    drain();

    $display("covered %0d images and %0d items, %0d results checked",
             images, sent_items, sb.checked);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("tb: failure");
    end
    $finish;
  end
endmodule
